// ----- hw/rtl/tgbc_pkg.sv -----
package tgbc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOADED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int CFG_DATA_W = 8;
  localparam int DIM_W      = 8;
  localparam int POS_W      = 21;
  localparam int SIZE_W     = 20;
  localparam int TILE_IDX_W = 14;

  // whole-pixel edge position fed to the tile divider
  localparam int PX_W  = 17;
  // linear tile index inside a loaded map (row * width + col)
  localparam int IDX_W = 16;
  // signed tile coordinate used for clamping
  localparam int COORD_W = PX_W + 2;

endpackage

// ----- hw/rtl/tile_grid_box_collision.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         start / busy              mode, tile_index, tile_blocked,
//                                                box_x, box_y, box_width, box_height
// result    out        done (one-cycle strobe)   blocked
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A tile write's result strobes on the cycle after it is accepted.
// A query passes the four box edges through the shared tile divider in turn, clamps
// the far edges to the map, then does one map read per tile and waits for the last
// read to return; it ends early on a hit or an empty range.
// Out-of-bounds or unloaded queries answer straight from the idle state.
// After reset the map is cleared one tile a cycle, all MAX_COLS * MAX_ROWS tiles,
// with busy high. The receiver cannot stall; done is one cycle.
module tile_grid_box_collision #(
  parameter int MAX_COLS  = 128,
  parameter int MAX_ROWS  = 128,
  parameter int TILE_SIZE = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  mode,
  input  logic [tgbc_pkg::TILE_IDX_W-1:0]       tile_index,
  input  logic                                  tile_blocked,
  input  logic signed [tgbc_pkg::POS_W-1:0]     box_x,
  input  logic signed [tgbc_pkg::POS_W-1:0]     box_y,
  input  logic [tgbc_pkg::SIZE_W-1:0]           box_width,
  input  logic [tgbc_pkg::SIZE_W-1:0]           box_height,
  output logic                                  done,
  output logic                                  blocked,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tgbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tgbc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TPX   = TILE_SIZE * 16;
  localparam bit TILE1 = (TILE_SIZE == 1);
  localparam int PX_W  = tgbc_pkg::PX_W;
  localparam int CW    = tgbc_pkg::COORD_W;
  localparam int DW    = tgbc_pkg::DIM_W;
  localparam int IW    = tgbc_pkg::IDX_W;
  localparam int SW    = tgbc_pkg::POS_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]      state;
  logic            map_loaded;
  logic [DW-1:0]   map_width_tiles;
  logic [DW-1:0]   map_height_tiles;

  logic            accept;
  logic            clearing;
  logic [SW-1:0]   sum_x, sum_y, end_x, end_y;
  logic [31:0]     wpx, hpx;
  logic            oob;

  logic [PX_W-1:0] px_op [4];
  logic [PX_W-1:0] coord [4];
  logic            c1_neg, r1_neg;
  logic [2:0]      div_cnt;
  logic [PX_W-1:0] div_q;

  logic signed [CW-1:0] c1s, r1s, wm1, hm1, c1c, r1c;
  logic            empty;

  logic [DW-1:0]   c0, c1, r1, cur_c, cur_r;
  logic [IW-1:0]   row_base, scan_idx;
  logic            last_tile;
  logic            rd_pend, rd_ok;
  logic            rd_data;
  logic            hit;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = clearing || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_loaded       <= 1'b0;
      map_width_tiles  <= '0;
      map_height_tiles <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgbc_pkg::CFG_MAP_LOADED: map_loaded       <= cfg_data[0];
        tgbc_pkg::CFG_MAP_WIDTH:  map_width_tiles  <= cfg_data;
        tgbc_pkg::CFG_MAP_HEIGHT: map_height_tiles <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounds check on the incoming box
  always_comb begin
    sum_x = {box_x[tgbc_pkg::POS_W-1], box_x} + SW'(box_width);
    sum_y = {box_y[tgbc_pkg::POS_W-1], box_y} + SW'(box_height);
    end_x = sum_x - SW'(16);
    end_y = sum_y - SW'(16);
    wpx   = 32'(map_width_tiles) * 32'(TPX);
    hpx   = 32'(map_height_tiles) * 32'(TPX);
    oob   = box_x[tgbc_pkg::POS_W-1] || box_y[tgbc_pkg::POS_W-1] ||
            (32'(sum_x) > wpx) || (32'(sum_y) > hpx);
  end

  tgbc_tile_div #(
    .TILE_SIZE (TILE_SIZE)
  ) u_div (
    .clk (clk),
    .px  (px_op[div_cnt[1:0]]),
    .q   (div_q)
  );

  // clamp far edges to the map and detect an empty range
  always_comb begin
    c1s   = c1_neg ? -CW'(1) : CW'(coord[1]);
    r1s   = r1_neg ? -CW'(1) : CW'(coord[3]);
    wm1   = CW'(map_width_tiles) - CW'(1);
    hm1   = CW'(map_height_tiles) - CW'(1);
    c1c   = (c1s > wm1) ? wm1 : c1s;
    r1c   = (r1s > hm1) ? hm1 : r1s;
    empty = (c1c < $signed(CW'(coord[0]))) || (r1c < $signed(CW'(coord[2])));
  end

  assign scan_idx  = row_base + IW'(cur_c);
  assign last_tile = (cur_c == c1) && (cur_r == r1);
  assign hit       = rd_pend && rd_ok && rd_data;

  tgbc_map_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && (mode == tgbc_pkg::MODE_WRITE) &&
               (32'(tile_index) < 32'(DEPTH))),
    .wr_addr  (AW'(tile_index)),
    .wr_data  (tile_blocked),
    .rd_addr  (AW'(scan_idx)),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
      div_cnt <= '0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if ((mode == tgbc_pkg::MODE_WRITE) || !map_loaded) begin
              done    <= 1'b1;
              blocked <= 1'b0;
            end else if (oob) begin
              done    <= 1'b1;
              blocked <= 1'b1;
            end else begin
              state   <= S_DIV;
              div_cnt <= '0;
            end
          end
        end
        S_DIV: begin
          if (div_cnt != 3'd0) begin
            coord[2'(div_cnt - 3'd1)] <= div_q;
          end
          if (div_cnt == 3'd4) begin
            state <= S_RANGE;
          end
          div_cnt <= div_cnt + 3'd1;
        end
        S_RANGE: begin
          if (empty) begin
            done    <= 1'b1;
            blocked <= 1'b0;
            state   <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= 1'b1;
          if (hit) begin
            done    <= 1'b1;
            blocked <= 1'b1;
            rd_pend <= 1'b0;
            state   <= S_IDLE;
          end else if (last_tile) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          done    <= 1'b1;
          blocked <= hit;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_op[0] <= PX_W'(box_x[tgbc_pkg::POS_W-2:4]);
      px_op[1] <= end_x[SW-1] ? '0 : end_x[PX_W+3:4];
      px_op[2] <= PX_W'(box_y[tgbc_pkg::POS_W-2:4]);
      px_op[3] <= end_y[SW-1] ? '0 : end_y[PX_W+3:4];
      c1_neg   <= TILE1 && (end_x == -SW'(16));
      r1_neg   <= TILE1 && (end_y == -SW'(16));
    end
    if (state == S_RANGE) begin
      c0       <= DW'(coord[0]);
      c1       <= DW'(c1c);
      r1       <= DW'(r1c);
      cur_c    <= DW'(coord[0]);
      cur_r    <= DW'(coord[2]);
      row_base <= IW'(DW'(coord[2])) * IW'(map_width_tiles);
    end else if (state == S_SCAN) begin
      rd_ok <= 32'(scan_idx) < 32'(DEPTH);
      if (cur_c == c1) begin
        cur_c    <= c0;
        cur_r    <= cur_r + DW'(1);
        row_base <= row_base + IW'(map_width_tiles);
      end else begin
        cur_c <= cur_c + DW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/tgbc_tile_div.sv -----
module tgbc_tile_div #(
  parameter int TILE_SIZE = 64
) (
  input  logic                         clk,
  input  logic [tgbc_pkg::PX_W-1:0]    px,
  output logic [tgbc_pkg::PX_W-1:0]    q
);

  localparam int DIV_K = tgbc_pkg::PX_W + $clog2(TILE_SIZE);
  localparam int MW    = DIV_K + 1;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_K) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE);
  localparam logic [MW-1:0] RECIP = MW'(DIV_M);

  logic [tgbc_pkg::PX_W+MW-1:0] prod;

  // exact floor(px / TILE_SIZE) via reciprocal multiply
  assign prod = (tgbc_pkg::PX_W+MW)'(px) * (tgbc_pkg::PX_W+MW)'(RECIP);

  always_ff @(posedge clk) begin
    q <= prod[DIV_K +: tgbc_pkg::PX_W];
  end

endmodule

// ----- hw/rtl/tgbc_map_mem.sv -----
module tgbc_map_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  output logic          clearing
);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- tb/tile_grid_box_collision_tb.sv -----
`timescale 1ns / 100ps

module tile_grid_box_collision_tb;

  localparam int MAX_COLS  = 128;
  localparam int MAX_ROWS  = 128;
  localparam int TILE_SIZE = 64;
  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
  localparam longint TILE_FIX = TILE_SIZE * 16;

  localparam logic [tgbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int SEGMENTS      = 6;
  localparam int SEG_ITEMS     = 290;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic                               mode;
    logic [tgbc_pkg::TILE_IDX_W-1:0]    tile_index;
    logic                               tile_blocked;
    logic signed [tgbc_pkg::POS_W-1:0]  x;
    logic signed [tgbc_pkg::POS_W-1:0]  y;
    logic [tgbc_pkg::SIZE_W-1:0]        w;
    logic [tgbc_pkg::SIZE_W-1:0]        h;
  } collide_txn_t;

  typedef enum logic {ROW_TXN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [tgbc_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [tgbc_pkg::CFG_DATA_W-1:0]    reg_data;
    collide_txn_t                       txn;
    logic                               known;
    logic                               known_blocked;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic [tgbc_pkg::TILE_IDX_W-1:0] tile_index = '0;
  logic tile_blocked = 1'b0;
  logic signed [tgbc_pkg::POS_W-1:0] box_x = '0;
  logic signed [tgbc_pkg::POS_W-1:0] box_y = '0;
  logic [tgbc_pkg::SIZE_W-1:0] box_width = '0;
  logic [tgbc_pkg::SIZE_W-1:0] box_height = '0;
  logic done;
  logic blocked;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tgbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tgbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit shadow_map [MAP_DEPTH];
  logic shadow_loaded = 1'b0;
  logic [tgbc_pkg::DIM_W-1:0] shadow_width = '0;
  logic [tgbc_pkg::DIM_W-1:0] shadow_height = '0;

  logic pending_blocked [$];
  plan_row_t plan_q [$];
  int unsigned gap_pct = 0;
  int err_count = 0;
  int results_seen = 0;
  logic want_blocked;

  tile_grid_box_collision #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TILE_SIZE(TILE_SIZE)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .tile_index  (tile_index),
    .tile_blocked(tile_blocked),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .done        (done),
    .blocked     (blocked),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("%0t ERROR: %s", $time, what);
    end
  endtask

  // truncation toward zero, as integer division does for negative values
  function automatic longint tile_coord(longint fixed);
    return (fixed / 16) / TILE_SIZE;
  endfunction

  function automatic logic predict_blocked(collide_txn_t t);
    longint x, y, w, h, wpx, hpx, c0, c1, r0, r1, r, c, pos;
    if (t.mode == tgbc_pkg::MODE_WRITE) begin
      if (t.tile_index < MAP_DEPTH) shadow_map[t.tile_index] = t.tile_blocked;
      return 1'b0;
    end
    if (!shadow_loaded) return 1'b0;
    x = longint'($signed(t.x));
    y = longint'($signed(t.y));
    w = longint'(t.w);
    h = longint'(t.h);
    wpx = longint'(shadow_width) * TILE_FIX;
    hpx = longint'(shadow_height) * TILE_FIX;
    if (x < 0 || y < 0 || x + w > wpx || y + h > hpx) return 1'b1;
    c0 = tile_coord(x);
    c1 = tile_coord(x + w - 16);
    r0 = tile_coord(y);
    r1 = tile_coord(y + h - 16);
    if (c1 > longint'(shadow_width) - 1) c1 = longint'(shadow_width) - 1;
    if (r1 > longint'(shadow_height) - 1) r1 = longint'(shadow_height) - 1;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        if (r < 0 || c < 0) continue;
        pos = r * longint'(shadow_width) + c;
        if (pos < MAP_DEPTH && shadow_map[pos]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void plan_txn(collide_txn_t t, logic known, logic kb);
    plan_row_t row;
    row = '0;
    row.kind = ROW_TXN;
    row.txn = t;
    row.known = known;
    row.known_blocked = kb;
    plan_q = {plan_q, row};
  endfunction

  function automatic void plan_query(longint x, longint y, longint w, longint h,
                                     logic known, logic kb);
    collide_txn_t t;
    t = '0;
    t.mode = tgbc_pkg::MODE_QUERY;
    t.x = tgbc_pkg::POS_W'(x);
    t.y = tgbc_pkg::POS_W'(y);
    t.w = tgbc_pkg::SIZE_W'(w);
    t.h = tgbc_pkg::SIZE_W'(h);
    plan_txn(t, known, kb);
  endfunction

  function automatic void plan_write(int idx, logic b);
    collide_txn_t t;
    t = '0;
    t.mode = tgbc_pkg::MODE_WRITE;
    t.tile_index = tgbc_pkg::TILE_IDX_W'(idx);
    t.tile_blocked = b;
    plan_txn(t, 1'b1, 1'b0);
  endfunction

  function automatic void plan_reg(logic [tgbc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [tgbc_pkg::CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_data = data;
    plan_q = {plan_q, row};
  endfunction

  function automatic logic [tgbc_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return tgbc_pkg::DIM_W'(MAX_COLS);
      2: return '1;
      default: return tgbc_pkg::DIM_W'($urandom_range(16, 1));
    endcase
  endfunction

  function automatic collide_txn_t random_txn();
    collide_txn_t t;
    int unsigned pick;
    longint wpx, hpx, bw, bh, px, py, tiles;
    t.mode = tgbc_pkg::MODE_QUERY;
    t.tile_index = tgbc_pkg::TILE_IDX_W'($urandom);
    t.tile_blocked = 1'($urandom);
    t.x = tgbc_pkg::POS_W'($urandom);
    t.y = tgbc_pkg::POS_W'($urandom);
    t.w = tgbc_pkg::SIZE_W'($urandom);
    t.h = tgbc_pkg::SIZE_W'($urandom);
    wpx = longint'(shadow_width) * TILE_FIX;
    hpx = longint'(shadow_height) * TILE_FIX;
    tiles = longint'(shadow_width) * longint'(shadow_height);
    if (tiles > MAP_DEPTH) tiles = MAP_DEPTH;
    pick = $urandom_range(99);
    if (pick < 30) begin
      t.mode = tgbc_pkg::MODE_WRITE;
      if (pick < 25) begin
        if (tiles > 0) begin
          t.tile_index = tgbc_pkg::TILE_IDX_W'($urandom_range(int'(tiles - 1)));
        end
        t.tile_blocked = ($urandom_range(9) < 3);
      end
    end else if (pick < 85) begin
      // one in a hundred draws its width from up to the full map width
      bw = (pick == 84) ? wpx : 3 * TILE_FIX;
      if (bw > wpx) bw = wpx;
      bw = longint'($urandom_range(int'(bw)));
      bh = 3 * TILE_FIX;
      if (bh > hpx) bh = hpx;
      bh = longint'($urandom_range(int'(bh)));
      px = longint'($urandom_range(int'(wpx - bw)));
      py = longint'($urandom_range(int'(hpx - bh)));
      if ($urandom_range(7) == 0) px = px + longint'($urandom_range(32)) - 16;
      if ($urandom_range(7) == 0) py = py + longint'($urandom_range(32)) - 16;
      t.x = tgbc_pkg::POS_W'(px);
      t.y = tgbc_pkg::POS_W'(py);
      t.w = tgbc_pkg::SIZE_W'(bw);
      t.h = tgbc_pkg::SIZE_W'(bh);
    end
    return t;
  endfunction

  task automatic settle();
    int n;
    start <= 1'b0;
    n = 0;
    while (pending_blocked.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_blocked.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_blocked.size()));
      pending_blocked.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tgbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [tgbc_pkg::CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      tgbc_pkg::CFG_MAP_LOADED: shadow_loaded = data[0];
      tgbc_pkg::CFG_MAP_WIDTH:  shadow_width = data;
      tgbc_pkg::CFG_MAP_HEIGHT: shadow_height = data;
      default: ;
    endcase
  endtask

  task automatic send_item(collide_txn_t t, logic known, logic kb);
    logic p;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= t.mode;
    tile_index   <= t.tile_index;
    tile_blocked <= t.tile_blocked;
    box_x        <= t.x;
    box_y        <= t.y;
    box_width    <= t.w;
    box_height   <= t.h;
    do @(posedge clk); while (busy !== 1'b0);
    p = predict_blocked(t);
    pending_blocked = {pending_blocked, (known ? kb : p)};
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (pending_blocked.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction outstanding",
                                  results_seen));
      end else begin
        want_blocked = pending_blocked.pop_front();
        if (blocked !== want_blocked) begin
          report_mismatch($sformatf("result %0d: blocked %b, expected %b",
                                    results_seen, blocked, want_blocked));
        end
      end
    end
  end

  initial begin
    logic loaded;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no map yet; writes still land
    plan_query(0, 0, 16, 16, 1'b1, 1'b0);
    plan_write(0, 1'b1);
    plan_reg(tgbc_pkg::CFG_MAP_LOADED, 8'h81);
    plan_reg(tgbc_pkg::CFG_MAP_WIDTH, 8'd4);
    plan_reg(tgbc_pkg::CFG_MAP_HEIGHT, 8'd3);
    plan_query(0, 0, 16, 16, 1'b0, 1'b0);
    plan_query(-16, 0, 16, 16, 1'b1, 1'b1);
    plan_query(0, -1048576, 16, 16, 1'b1, 1'b1);
    plan_query(4080, 0, 32, 16, 1'b1, 1'b1);
    plan_query(1048575, 0, 16, 16, 1'b1, 1'b1);
    plan_query(0, 0, 16, 3073, 1'b1, 1'b1);
    plan_query(0, 0, 1048575, 1048575, 1'b1, 1'b1);
    plan_write(1, 1'b1);
    // zero size at a tile's left edge: empty column range; zero size past the edge still covers a tile
    plan_query(1024, 0, 0, 16, 1'b0, 1'b0);
    plan_query(1040, 16, 0, 0, 1'b0, 1'b0);
    // right edge one pixel left of zero truncates back to column 0
    plan_query(0, 0, 0, 0, 1'b0, 1'b0);
    plan_query(0, 0, 4096, 3072, 1'b0, 1'b0);
    plan_write(0, 1'b0);
    plan_write(1, 1'b0);
    plan_write(MAP_DEPTH - 1, 1'b1);
    // wide map: rows past the store read as clear
    plan_reg(tgbc_pkg::CFG_MAP_WIDTH, 8'd255);
    plan_reg(tgbc_pkg::CFG_MAP_HEIGHT, 8'd255);
    plan_query(64512, 65536, 16, 16, 1'b0, 1'b0);
    plan_query(0, 66560, 16, 16, 1'b0, 1'b0);
    plan_query(0, 0, 261120, 16, 1'b0, 1'b0);
    plan_reg(tgbc_pkg::CFG_MAP_WIDTH, 8'd0);
    plan_reg(tgbc_pkg::CFG_MAP_HEIGHT, 8'd0);
    plan_reg(CFG_UNUSED, 8'hFF);
    plan_query(0, 0, 16, 0, 1'b1, 1'b1);
    plan_query(0, 0, 0, 0, 1'b0, 1'b0);
    plan_reg(tgbc_pkg::CFG_MAP_LOADED, 8'hFE);
    plan_query(0, 0, 16, 16, 1'b1, 1'b0);
    plan_reg(tgbc_pkg::CFG_MAP_LOADED, 8'h01);
    plan_reg(tgbc_pkg::CFG_MAP_WIDTH, 8'd128);
    plan_reg(tgbc_pkg::CFG_MAP_HEIGHT, 8'd128);
    plan_query(0, 0, 131072, 131072, 1'b0, 1'b0);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_REG) begin
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_data);
      end else begin
        send_item(plan_q[i].txn, plan_q[i].known, plan_q[i].known_blocked);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      gap_pct = (seg < 2) ? 7 : (seg < 4) ? 68 : 0;
      loaded = ($urandom_range(7) != 0);
      write_reg(tgbc_pkg::CFG_MAP_LOADED, {7'($urandom), loaded});
      write_reg(tgbc_pkg::CFG_MAP_WIDTH, pick_dim());
      write_reg(tgbc_pkg::CFG_MAP_HEIGHT, pick_dim());
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if ($urandom_range(199) == 0) settle();
        send_item(random_txn(), 1'b0, 1'b0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
